>>> sv/wufc_pkg.sv
// shared constants, types and microprogram of the union-find unit
`default_nettype none

package wufc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SIZE_W    = NODE_W + 1;
    localparam int CFG_W     = 11;
    localparam int LINK_W    = 10;
    localparam int PAIR_W    = 32;

    localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = CFG_W'(MAX_NODES);
    localparam logic [CFG_W-1:0]  LIMIT_MAX        = CFG_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] LAST_NODE        = NODE_W'(MAX_NODES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_FIND_A,
        S_ISSUE_B,
        S_FIND_B,
        S_COMPARE,
        S_SIZE_A,
        S_LINK,
        S_ISSUE_PA,
        S_FLAT_A,
        S_ISSUE_PB,
        S_FLAT_B,
        S_REPLY
    } step_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_A,
        RD_B,
        RD_CHAIN,
        RD_SIZE_RA,
        RD_SIZE_RB
    } rd_mode_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LINK,
        WR_FLAT
    } wr_mode_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_CLR_MORE,
        C_INPUT,
        C_BAD,
        C_NOT_ROOT,
        C_SAME,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        rd_mode_t rd;
        wr_mode_t wr;
        logic     ld_ra;
        logic     ld_rb;
        logic     ld_sa;
        logic     ld_root;
        logic     cnt_pair;
        logic     in_ready;
        logic     out_load;
        cond_t    cond;
        step_t    jt;
        step_t    jf;
    } ctl_t;

    // microprogram: one control word per step, jump to jt when cond holds, else jf
    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        c = '{rd: RD_NONE, wr: WR_NONE, ld_ra: 1'b0, ld_rb: 1'b0, ld_sa: 1'b0,
              ld_root: 1'b0, cnt_pair: 1'b0, in_ready: 1'b0, out_load: 1'b0,
              cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE};
        case (s)
            S_CLEAR: begin
                c.wr = WR_CLEAR; c.cond = C_CLR_MORE; c.jt = S_CLEAR; c.jf = S_IDLE;
            end
            S_IDLE: begin
                c.in_ready = 1'b1; c.cond = C_INPUT; c.jt = S_START; c.jf = S_IDLE;
            end
            S_START: begin
                c.rd = RD_A; c.cnt_pair = 1'b1;
                c.cond = C_BAD; c.jt = S_REPLY; c.jf = S_FIND_A;
            end
            S_FIND_A: begin
                c.rd = RD_CHAIN; c.ld_ra = 1'b1;
                c.cond = C_NOT_ROOT; c.jt = S_FIND_A; c.jf = S_ISSUE_B;
            end
            S_ISSUE_B: begin
                c.rd = RD_B; c.jt = S_FIND_B;
            end
            S_FIND_B: begin
                c.rd = RD_CHAIN; c.ld_rb = 1'b1;
                c.cond = C_NOT_ROOT; c.jt = S_FIND_B; c.jf = S_COMPARE;
            end
            S_COMPARE: begin
                c.rd = RD_SIZE_RA; c.ld_root = 1'b1;
                c.cond = C_SAME; c.jt = S_REPLY; c.jf = S_SIZE_A;
            end
            S_SIZE_A: begin
                c.rd = RD_SIZE_RB; c.ld_sa = 1'b1; c.jt = S_LINK;
            end
            S_LINK: begin
                c.wr = WR_LINK; c.jt = S_ISSUE_PA;
            end
            S_ISSUE_PA: begin
                c.rd = RD_A; c.jt = S_FLAT_A;
            end
            S_FLAT_A: begin
                c.rd = RD_CHAIN; c.wr = WR_FLAT;
                c.cond = C_NOT_ROOT; c.jt = S_FLAT_A; c.jf = S_ISSUE_PB;
            end
            S_ISSUE_PB: begin
                c.rd = RD_B; c.jt = S_FLAT_B;
            end
            S_FLAT_B: begin
                c.rd = RD_CHAIN; c.wr = WR_FLAT;
                c.cond = C_NOT_ROOT; c.jt = S_FLAT_B; c.jf = S_REPLY;
            end
            S_REPLY: begin
                c.out_load = 1'b1; c.cond = C_OUT_FREE; c.jt = S_IDLE; c.jf = S_REPLY;
            end
            default: begin
                c.jt = S_IDLE; c.jf = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/wufc_ram.sv
// simple dual-port ram, one write port and one registered read port
`default_nettype none

module wufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/weighted_union_find_compressed_unit.sv
// top level: weighted union-find with path compression, microcoded control
// After reset the unit writes every parent entry to its own
// index and every tree size to one; s_ready stays low meanwhile, node-count
// writes are taken at any time. Each pair then runs a short microprogram that
// walks parent pointers one per cycle through the single read port of the parent
// store. A rejected pair goes straight to the result; an already connected pair
// walks the paths from each node to its root; a pair that is linked walks them
// a second time, rewriting each visited node to the new root. Weighted
// linking keeps paths short. Results sit in an output register, so the next pair
// may be accepted while a result still waits for m_ready.
`default_nettype none

module weighted_union_find_compressed_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wufc_pkg::CFG_W-1:0]    cfg_node_count,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [wufc_pkg::NODE_W-1:0]   s_first_node,
    input  wire logic [wufc_pkg::NODE_W-1:0]   s_second_node,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_linked,
    output logic                               m_bad_index,
    output logic      [wufc_pkg::NODE_W-1:0]   m_common_root,
    output logic      [wufc_pkg::LINK_W-1:0]   m_links_total,
    output logic      [wufc_pkg::PAIR_W-1:0]   m_pairs_total
);

    localparam int NW = wufc_pkg::NODE_W;
    localparam int SW = wufc_pkg::SIZE_W;
    localparam int CW = wufc_pkg::CFG_W;

    // sequencer
    wufc_pkg::step_t upc_reg, upc_next;
    wufc_pkg::ctl_t  ctl;
    logic            cond_true;

    // control and counters
    logic [CW-1:0]               node_count_reg, node_count_next;
    logic [NW-1:0]               clr_reg, clr_next;
    logic [wufc_pkg::LINK_W-1:0] link_cnt_reg, link_cnt_next;
    logic [wufc_pkg::PAIR_W-1:0] pair_cnt_reg, pair_cnt_next;
    logic                        m_valid_reg, m_valid_next;

    // datapath
    logic [NW-1:0] a_reg, a_next;
    logic [NW-1:0] b_reg, b_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] ra_reg, ra_next;
    logic [NW-1:0] rb_reg, rb_next;
    logic [NW-1:0] root_reg, root_next;
    logic [SW-1:0] sa_reg, sa_next;
    logic          bad_reg, bad_next;
    logic          linked_reg, linked_next;

    // result register
    logic                        out_linked_reg, out_linked_next;
    logic                        out_bad_reg, out_bad_next;
    logic [NW-1:0]               out_root_reg, out_root_next;
    logic [wufc_pkg::LINK_W-1:0] out_links_reg, out_links_next;
    logic [wufc_pkg::PAIR_W-1:0] out_pairs_reg, out_pairs_next;

    // memory ports
    logic          p_we, s_we;
    logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [NW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;

    logic [CW-1:0] limit;
    logic          accept, out_free, not_root, a_smaller;
    logic [NW-1:0] win_root, lose_root;
    logic [SW-1:0] size_sum;

    wufc_ram #(.WIDTH(NW), .DEPTH(wufc_pkg::MAX_NODES)) u_parent (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    wufc_ram #(.WIDTH(SW), .DEPTH(wufc_pkg::MAX_NODES)) u_size (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign limit     = (node_count_reg > wufc_pkg::LIMIT_MAX) ? wufc_pkg::LIMIT_MAX
                                                              : node_count_reg;
    assign not_root  = (p_rdata != n_reg);
    assign out_free  = !m_valid_reg || m_ready;
    // ties go to the first node's root
    assign a_smaller = (sa_reg < s_rdata);
    assign win_root  = a_smaller ? rb_reg : ra_reg;
    assign lose_root = a_smaller ? ra_reg : rb_reg;
    assign size_sum  = SW'(sa_reg + s_rdata);

    assign cfg_ready = 1'b1;
    assign s_ready   = ctl.in_ready;
    assign accept    = s_valid && ctl.in_ready;

    // control word output
    always_comb begin
        ctl = wufc_pkg::ucode(upc_reg);
    end

    // next step
    always_comb begin
        case (ctl.cond)
            wufc_pkg::C_ALWAYS:   cond_true = 1'b1;
            wufc_pkg::C_CLR_MORE: cond_true = (clr_reg != wufc_pkg::LAST_NODE);
            wufc_pkg::C_INPUT:    cond_true = s_valid;
            wufc_pkg::C_BAD:      cond_true = bad_reg;
            wufc_pkg::C_NOT_ROOT: cond_true = not_root;
            wufc_pkg::C_SAME:     cond_true = (ra_reg == rb_reg);
            wufc_pkg::C_OUT_FREE: cond_true = out_free;
            default:              cond_true = 1'b1;
        endcase
        upc_next = cond_true ? ctl.jt : ctl.jf;
    end

    // memory addressing
    always_comb begin
        case (ctl.rd)
            wufc_pkg::RD_A: p_raddr = a_reg;
            wufc_pkg::RD_B: p_raddr = b_reg;
            default:        p_raddr = p_rdata;
        endcase
        s_raddr = (ctl.rd == wufc_pkg::RD_SIZE_RB) ? rb_reg : ra_reg;

        p_we    = 1'b0;
        p_waddr = n_reg;
        p_wdata = root_reg;
        s_we    = 1'b0;
        s_waddr = win_root;
        s_wdata = size_sum;
        case (ctl.wr)
            wufc_pkg::WR_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = clr_reg;
                s_we    = 1'b1;
                s_waddr = clr_reg;
                s_wdata = SW'(1);
            end
            wufc_pkg::WR_LINK: begin
                p_we    = 1'b1;
                p_waddr = lose_root;
                p_wdata = win_root;
                s_we    = 1'b1;
            end
            wufc_pkg::WR_FLAT: begin
                p_we = not_root;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        node_count_next = node_count_reg;
        clr_next        = clr_reg;
        link_cnt_next   = link_cnt_reg;
        pair_cnt_next   = pair_cnt_reg;
        m_valid_next    = m_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        n_next          = n_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        root_next       = root_reg;
        sa_next         = sa_reg;
        bad_next        = bad_reg;
        linked_next     = linked_reg;
        out_linked_next = out_linked_reg;
        out_bad_next    = out_bad_reg;
        out_root_next   = out_root_reg;
        out_links_next  = out_links_reg;
        out_pairs_next  = out_pairs_reg;

        if (cfg_valid) begin
            node_count_next = cfg_node_count;
        end

        if (ctl.wr == wufc_pkg::WR_CLEAR) begin
            clr_next = clr_reg + NW'(1);
        end

        if (accept) begin
            a_next      = s_first_node;
            b_next      = s_second_node;
            bad_next    = (CW'(s_first_node) >= limit) || (CW'(s_second_node) >= limit);
            linked_next = 1'b0;
        end

        case (ctl.rd)
            wufc_pkg::RD_A:     n_next = a_reg;
            wufc_pkg::RD_B:     n_next = b_reg;
            wufc_pkg::RD_CHAIN: n_next = p_rdata;
            default:            n_next = n_reg;
        endcase

        if (ctl.cnt_pair && !bad_reg && (pair_cnt_reg != '1)) begin
            pair_cnt_next = pair_cnt_reg + wufc_pkg::PAIR_W'(1);
        end
        if (ctl.ld_ra) begin
            ra_next = p_rdata;
        end
        if (ctl.ld_rb) begin
            rb_next = p_rdata;
        end
        if (ctl.ld_root) begin
            root_next = ra_reg;
        end
        if (ctl.ld_sa) begin
            sa_next = s_rdata;
        end
        if (ctl.wr == wufc_pkg::WR_LINK) begin
            root_next     = win_root;
            linked_next   = 1'b1;
            link_cnt_next = link_cnt_reg + wufc_pkg::LINK_W'(1);
        end

        // output register: load frees the sequencer, m_ready drains it
        if (ctl.out_load && out_free) begin
            m_valid_next    = 1'b1;
            out_linked_next = linked_reg;
            out_bad_next    = bad_reg;
            out_root_next   = bad_reg ? '0 : root_reg;
            out_links_next  = link_cnt_reg;
            out_pairs_next  = pair_cnt_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= wufc_pkg::S_CLEAR;
            node_count_reg <= wufc_pkg::NODE_COUNT_RESET;
            clr_reg        <= '0;
            link_cnt_reg   <= '0;
            pair_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            upc_reg        <= upc_next;
            node_count_reg <= node_count_next;
            clr_reg        <= clr_next;
            link_cnt_reg   <= link_cnt_next;
            pair_cnt_reg   <= pair_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        n_reg          <= n_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        root_reg       <= root_next;
        sa_reg         <= sa_next;
        bad_reg        <= bad_next;
        linked_reg     <= linked_next;
        out_linked_reg <= out_linked_next;
        out_bad_reg    <= out_bad_next;
        out_root_reg   <= out_root_next;
        out_links_reg  <= out_links_next;
        out_pairs_reg  <= out_pairs_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_linked      = out_linked_reg;
    assign m_bad_index   = out_bad_reg;
    assign m_common_root = out_root_reg;
    assign m_links_total = out_links_reg;
    assign m_pairs_total = out_pairs_reg;

endmodule

`default_nettype wire

>>> sv/wufc_props.sv
// port-level checks on the union-find unit, bound to the top level
`default_nettype none

module wufc_props (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_linked,
    input wire logic                          m_bad_index,
    input wire logic [wufc_pkg::NODE_W-1:0]   m_common_root,
    input wire logic [wufc_pkg::LINK_W-1:0]   m_links_total,
    input wire logic [wufc_pkg::PAIR_W-1:0]   m_pairs_total
);

    // a result waiting for transfer keeps its counters
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_links_total)
                               && $stable(m_pairs_total))
        else $error("result changed while stalled");

    // a rejected pair never links
    a_bad_no_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_index |-> !m_linked)
        else $error("rejected pair reported as linked");

    // a rejected pair reports root zero
    a_bad_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_index |-> m_common_root == '0)
        else $error("rejected pair reported a root");

    // a link is made only for a counted pair
    a_link_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_linked |-> m_pairs_total != '0)
        else $error("link without counted pair");

endmodule

bind weighted_union_find_compressed_unit wufc_props u_props (.*);

`default_nettype wire

>>> tb/sv/tb_weighted_union_find_compressed_unit.sv
// self-checking testbench for the weighted union-find unit with path compression
`timescale 1ns / 100ps

module tb_weighted_union_find_compressed_unit;

    import wufc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        node_t first;
        node_t second;
    } node_pair_t;

    typedef struct packed {
        logic               linked;
        logic               bad_index;
        node_t              common_root;
        logic [LINK_W-1:0]  links_total;
        logic [PAIR_W-1:0]  pairs_total;
    } pair_result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_node_count = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    node_t               s_first_node   = '0;
    node_t               s_second_node  = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_linked;
    logic                m_bad_index;
    node_t               m_common_root;
    logic [LINK_W-1:0]   m_links_total;
    logic [PAIR_W-1:0]   m_pairs_total;

    // predicted state of the forest
    node_t               forest_parent [MAX_NODES];
    logic [SIZE_W-1:0]   tree_size [MAX_NODES];
    logic [LINK_W-1:0]   links_done  = '0;
    logic [PAIR_W-1:0]   pairs_done  = '0;
    logic [CFG_W-1:0]    node_limit  = NODE_COUNT_RESET;

    node_pair_t          pair_feed [$];
    pair_result_t        expected_results [$];
    node_pair_t          next_pair;
    pair_result_t        want;

    int                  items_queued  = 0;
    int                  results_count = 0;
    int                  failures      = 0;
    int                  cycle_count   = 0;
    int                  in_gap        = 0;
    int                  out_wait      = 0;
    int                  sent_count    = 0;
    bit                  in_calm       = 1'b0;
    bit                  out_calm      = 1'b0;
    bit                  timed_out     = 1'b0;

    weighted_union_find_compressed_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_node_count (cfg_node_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_node   (s_first_node),
        .s_second_node  (s_second_node),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linked       (m_linked),
        .m_bad_index    (m_bad_index),
        .m_common_root  (m_common_root),
        .m_links_total  (m_links_total),
        .m_pairs_total  (m_pairs_total)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic node_t find_top(node_t n);
        node_t up;
        for (int k = 0; k < MAX_NODES; k++) begin
            up = forest_parent[n];
            if (up == n)
                break;
            n = up;
        end
        return n;
    endfunction

    function automatic void point_path_at(node_t n, node_t top);
        node_t up;
        for (int k = 0; k < MAX_NODES; k++) begin
            up = forest_parent[n];
            if (up == n)
                break;
            forest_parent[n] = top;
            n = up;
        end
    endfunction

    // joins the sets of a and b, returns the result the unit should report
    function automatic pair_result_t resolve_pair(node_t a, node_t b);
        pair_result_t r;
        logic [CFG_W-1:0] lim;
        node_t ra;
        node_t rb;
        r = '0;
        lim = (node_limit > LIMIT_MAX) ? LIMIT_MAX : node_limit;
        if ({1'b0, a} >= lim || {1'b0, b} >= lim) begin
            r.bad_index = 1'b1;
        end else begin
            if (pairs_done != '1)
                pairs_done = pairs_done + 1'b1;
            ra = find_top(a);
            rb = find_top(b);
            if (ra == rb) begin
                r.common_root = ra;
            end else begin
                // ties keep the first node's root on top
                if (tree_size[ra] < tree_size[rb]) begin
                    forest_parent[ra] = rb;
                    tree_size[rb] = tree_size[rb] + tree_size[ra];
                    r.common_root = rb;
                end else begin
                    forest_parent[rb] = ra;
                    tree_size[ra] = tree_size[ra] + tree_size[rb];
                    r.common_root = ra;
                end
                links_done = links_done + 1'b1;
                r.linked = 1'b1;
                point_path_at(a, r.common_root);
                point_path_at(b, r.common_root);
            end
        end
        r.links_total = links_done;
        r.pairs_total = pairs_done;
        return r;
    endfunction

    function automatic node_t pick_node(int span);
        if (span == 0 || $urandom_range(0, 9) == 0)
            return node_t'($urandom_range(0, MAX_NODES - 1));
        return node_t'($urandom_range(0, span - 1));
    endfunction

    task automatic queue_pair(input int a, input int b);
        pair_feed.push_back('{first: node_t'(a), second: node_t'(b)});
        items_queued++;
    endtask

    task automatic queue_random_pairs(input int count, input int span);
        for (int i = 0; i < count; i++)
            queue_pair(pick_node(span), pick_node(span));
    endtask

    task automatic wait_drained();
        while (results_count != items_queued)
            @(posedge aclk);
    endtask

    task automatic change_node_count(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_node_count <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_limit = value;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, got_v);
        end
    endtask

    // sender: one pair per transfer, with a random gap ahead of each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(resolve_pair(s_first_node, s_second_node));
                sent_count++;
                if (sent_count % 40 == 0)
                    in_calm = ($urandom_range(0, 3) == 0);
                in_gap = in_calm ? 0 : $urandom_range(0, 5);
            end
            if (!(s_valid && !s_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pair_feed.size() != 0) begin
                    next_pair = pair_feed.pop_front();
                    s_valid       <= 1'b1;
                    s_first_node  <= next_pair.first;
                    s_second_node <= next_pair.second;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transfer, then may hold m_ready low at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: result with nothing expected, expected none, actual root %0d",
                             $time, m_common_root);
                end else begin
                    want = expected_results.pop_front();
                    check_field("linked", 32'(want.linked), 32'(m_linked));
                    check_field("bad_index", 32'(want.bad_index), 32'(m_bad_index));
                    check_field("common_root", 32'(want.common_root), 32'(m_common_root));
                    check_field("links_total", 32'(want.links_total), 32'(m_links_total));
                    check_field("pairs_total", want.pairs_total, m_pairs_total);
                    results_count++;
                end
                if (results_count % 40 == 0)
                    out_calm = ($urandom_range(0, 3) == 0);
                out_wait = out_calm ? 0 : $urandom_range(0, 5);
                // long hold-off so the output register fills and input backs up
                if (results_count == HOLD_AT)
                    out_wait = HOLD_CYCLES;
            end
            if (out_wait > 0) begin
                out_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int k = 0; k < MAX_NODES; k++) begin
            forest_parent[k] = node_t'(k);
            tree_size[k]     = SIZE_W'(1);
        end
        fork
            begin
                repeat (4) @(posedge aclk);
                aresetn <= 1'b1;

                // reset node count: singletons, ties, smaller tree joining larger
                queue_pair(0, 0);
                queue_pair(1023, 1023);
                queue_pair(0, 1023);
                queue_pair(1023, 5);
                queue_pair(6, 0);
                queue_pair(5, 6);
                queue_pair(1, 2);
                queue_pair(3, 4);
                queue_pair(2, 4);
                // two-level path, left alone when connected, flattened on a union
                queue_pair(7, 8);
                queue_pair(9, 10);
                queue_pair(7, 9);
                queue_pair(10, 7);
                queue_pair(10, 11);
                queue_pair(512, 11);

                // one node in use
                change_node_count(CFG_W'(1));
                queue_pair(0, 0);
                queue_pair(0, 1);
                queue_pair(1, 0);
                queue_pair(1023, 1023);

                // nothing in use, every pair rejected
                change_node_count(CFG_W'(0));
                queue_pair(0, 0);
                queue_pair(1023, 0);

                // counts above the store size act as the full size
                change_node_count(CFG_W'(2047));
                queue_pair(1023, 512);
                change_node_count(CFG_W'(1025));
                queue_pair(1022, 1021);

                change_node_count(CFG_W'(1024));
                queue_random_pairs(150, 1024);
                queue_random_pairs(150, 48);

                change_node_count(CFG_W'(16));
                queue_random_pairs(100, 16);

                change_node_count(CFG_W'(2047));
                queue_random_pairs(150, 200);

                change_node_count(CFG_W'(300));
                queue_random_pairs(100, 300);

                change_node_count(CFG_W'($urandom_range(1, 1024)));
                queue_random_pairs(100, int'(node_limit));

                wait_drained();
                repeat (64) @(posedge aclk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge aclk);
                    cycle_count++;
                end
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && failures == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
